>>> sv/double_array_trie_stream_matcher_top_macros.svh
// assertion helpers for the trie matcher
`ifndef DOUBLE_ARRAY_TRIE_STREAM_MATCHER_TOP_MACROS_SVH
`define DOUBLE_ARRAY_TRIE_STREAM_MATCHER_TOP_MACROS_SVH

// next-cycle implication, masked while in reset
`define DATSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live during reset
`define DATSM_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/datsm_pkg.sv
package datsm_pkg;

  localparam int CODE_W     = 12;
  localparam int BASE_W     = 13;
  localparam int FAIL_W     = 12;
  localparam int LEN_IN_W   = 6;
  localparam int STATE_W    = 13;
  localparam int MAX_PASSES = 17;
  localparam int PASS_W     = 5;
  localparam int IN_TDATA_W = 72;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_SYMBOL = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  typedef struct packed {
    logic push;
    logic flush;
  } out_ctl_t;

endpackage

>>> sv/datsm_ram.sv
module datsm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/datsm_out_stage.sv
module datsm_out_stage #(
  parameter int POSITION_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  datsm_pkg::out_ctl_t            ctl,
  input  logic [POSITION_BITS:0]         in_start,
  input  logic [POSITION_BITS-1:0]       in_end,
  output logic                           out_free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [((2*POSITION_BITS+8)/8)*8-1:0] m_tdata,
  output logic                           m_tlast
);
  import datsm_pkg::*;

  localparam int PB  = POSITION_BITS;
  localparam int ODW = ((2*PB+8)/8)*8;

  logic            hold_valid;
  logic [PB:0]     hold_start;
  logic [PB-1:0]   hold_end;
  logic [PB:0]     out_start;
  logic [PB-1:0]   out_end;

  // one result is held back so that the last of a run can be flagged
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(ODW-2*PB-1){1'b0}}, out_end, out_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_free) begin
        if (ctl.push) begin
          if (hold_valid) begin
            m_tvalid  <= 1'b1;
            out_start <= hold_start;
            out_end   <= hold_end;
            m_tlast   <= 1'b0;
          end
          hold_start <= in_start;
          hold_end   <= in_end;
          hold_valid <= 1'b1;
        end else if (ctl.flush && hold_valid) begin
          m_tvalid   <= 1'b1;
          out_start  <= hold_start;
          out_end    <= hold_end;
          m_tlast    <= 1'b1;
          hold_valid <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/double_array_trie_stream_matcher_top.sv
// symbol request: passes of node read, check read and decision, then a done step that
//   flushes its last result (maximum mode reads the new state after each decision);
//   end-of-text request: one node read, then the done step; table write: no result
// one request at a time; one pass per node/check read round trip, plus back-pressure stalls
// reset: rst synchronous, then a clearing pass zeroes every entry of all tables
//   with s_tready low; mode, state and position reset to zero
module double_array_trie_stream_matcher_top #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int MAX_WORD_LEN  = 63,
  parameter int POSITION_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  // config: match_mode
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // symbol_code, entry_index, entry_base, entry_check, entry_failure, entry_word_length
  input  logic [datsm_pkg::IN_TDATA_W-1:0] s_tdata,
  // req_type
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // match_start, match_end
  output logic [((2*POSITION_BITS+8)/8)*8-1:0] m_tdata,
  // last_of_run
  output logic        m_tlast
);
  import datsm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int PB = POSITION_BITS;
  localparam int NW = BASE_W + FAIL_W + LW;
  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(MAX_PASSES - 1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOADN = 3'd2;  // node read issued
  localparam logic [2:0] ST_NODE  = 3'd3;  // node data back, check read issued
  localparam logic [2:0] ST_DEC   = 3'd4;  // check data back, transition decided
  localparam logic [2:0] ST_DONE  = 3'd5;

  // request fields
  logic [CODE_W-1:0]         in_code;
  logic [11:0]               in_idx;
  logic signed [BASE_W-1:0]  in_base;
  logic signed [BASE_W-1:0]  in_check;
  logic [FAIL_W-1:0]         in_fail;
  logic [LEN_IN_W-1:0]       in_len;
  logic [LW-1:0]             in_len_sat;

  assign in_code  = s_tdata[11:0];
  assign in_idx   = s_tdata[23:12];
  assign in_base  = s_tdata[36:24];
  assign in_check = s_tdata[49:37];
  assign in_fail  = s_tdata[61:50];
  assign in_len   = s_tdata[67:62];
  // word lengths above the limit saturate
  assign in_len_sat = (32'(in_len) > MAX_WORD_LEN) ? LW'(MAX_WORD_LEN) : LW'(in_len);

  logic [2:0]            st;
  logic [AW-1:0]         clr_addr;
  logic                  mode;
  logic [STATE_W-1:0]    cur_state;
  logic [PB-1:0]         pos;
  logic [STATE_W-1:0]    p;
  logic [CODE_W-1:0]     code;
  logic                  is_end;
  logic [PASS_W-1:0]     pass;
  logic                  pend;       // report owed for state p
  logic [PB-1:0]         pend_end;
  logic                  cont;       // another pass follows the pending report
  logic signed [BASE_W-1:0] nb;
  logic [FAIL_W-1:0]     nf;
  logic [LW-1:0]         nl;
  logic [STATE_W-1:0]    b_reg;
  logic                  a_ok;
  logic                  c_ok;

  logic                  accept;
  logic                  out_free;
  out_ctl_t              ctl;
  logic [PB:0]           rep_start;
  logic [PB-1:0]         rep_end;
  logic [LW-1:0]         rep_len;

  // memory ports
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [NW-1:0]         node_wdata;
  logic [BASE_W-1:0]     check_wdata;
  logic [NW-1:0]         node_rdata;
  logic [BASE_W-1:0]     check_rdata;
  logic [AW-1:0]         check_raddr;

  // node read decode, out-of-range reads give zero
  logic signed [BASE_W-1:0] node_base;
  logic [FAIL_W-1:0]     node_fail;
  logic [LW-1:0]         node_len;
  logic [BASE_W:0]       abs_base;
  logic [STATE_W-1:0]    b_calc;

  assign node_base = a_ok ? node_rdata[NW-1 -: BASE_W] : '0;
  assign node_fail = a_ok ? node_rdata[LW +: FAIL_W] : '0;
  assign node_len  = a_ok ? node_rdata[LW-1:0] : '0;
  assign abs_base  = node_base[BASE_W-1] ? -{node_base[BASE_W-1], node_base}
                                         : {node_base[BASE_W-1], node_base};
  assign b_calc    = STATE_W'(abs_base) + STATE_W'(code);
  assign check_raddr = AW'(b_calc);

  // transition rules on the check result
  logic signed [BASE_W-1:0] chk;
  logic [STATE_W-1:0]    newp;
  logic                  again;
  logic                  rep;

  assign chk = c_ok ? check_rdata : '0;

  always_comb begin
    newp  = p;
    again = 1'b0;
    rep   = 1'b0;
    if (code == '0) begin
      rep  = 1'b1;
      newp = '0;
    end else if ({chk[BASE_W-1], chk} == {1'b0, p}) begin
      newp = b_reg;
    end else if (chk == -13'sd1 && p == '0) begin
      newp = b_reg;
    end else if (nf != '0) begin
      rep   = 1'b1;
      newp  = STATE_W'(nf);
      again = 1'b1;
    end else if (p == '0) begin
      rep = 1'b1;
    end else begin
      rep   = 1'b1;
      newp  = '0;
      again = 1'b1;
    end
  end

  // report generation: node phase for owed reports, decision for all-match, done flushes
  always_comb begin
    ctl      = '0;
    rep_end  = pos;
    rep_len  = nl;
    case (st)
      ST_NODE: begin
        ctl.push = pend && node_base[BASE_W-1];
        rep_end  = pend_end;
        rep_len  = node_len;
      end
      ST_DEC: begin
        ctl.push = !mode && rep && nb[BASE_W-1];
      end
      ST_DONE: begin
        ctl.flush = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end
  assign rep_start = {1'b0, rep_end} - (PB+1)'(rep_len);

  assign s_tready = (st == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // table writes happen only while idle or clearing; read data is used only while busy
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = clr_addr;
    node_wdata  = '0;
    check_wdata = '0;
    if (st == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && s_tuser == REQ_WRITE && 32'(in_idx) < TABLE_DEPTH) begin
      mem_we      = 1'b1;
      mem_waddr   = AW'(in_idx);
      node_wdata  = {in_base, in_fail, in_len_sat};
      check_wdata = in_check;
    end
  end

  always_ff @(posedge clk) begin
    a_ok <= (32'(p) < TABLE_DEPTH);
    c_ok <= (32'(b_calc) < TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_addr  <= '0;
      mode      <= 1'b0;
      cur_state <= '0;
      pos       <= '0;
      pend      <= 1'b0;
      cont      <= 1'b0;
      is_end    <= 1'b0;
      pass      <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      case (st)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == TABLE_DEPTH - 1) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            p <= cur_state;
            code <= in_code;
            pass <= '0;
            if (s_tuser == REQ_SYMBOL) begin
              is_end <= 1'b0;
              pend   <= 1'b0;
              cont   <= 1'b1;
              st     <= ST_LOADN;
            end else if (s_tuser == REQ_END) begin
              is_end   <= 1'b1;
              pend     <= !mode;
              pend_end <= pos;
              cont     <= 1'b0;
              st       <= ST_LOADN;
            end
          end
        end
        ST_LOADN: begin
          st <= ST_NODE;
        end
        ST_NODE: begin
          if (out_free) begin
            pend  <= 1'b0;
            nb    <= node_base;
            nf    <= node_fail;
            nl    <= node_len;
            b_reg <= b_calc;
            st    <= cont ? ST_DEC : ST_DONE;
          end
        end
        ST_DEC: begin
          if (out_free) begin
            p    <= newp;
            pass <= pass + 1'b1;
            cont <= again && (pass != LAST_PASS);
            if (mode) begin
              // maximum rule: read the new state to report it
              pend     <= 1'b1;
              pend_end <= again ? pos : pos + 1'b1;
              st       <= ST_LOADN;
            end else begin
              st <= (again && pass != LAST_PASS) ? ST_LOADN : ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            cur_state <= is_end ? '0 : p;
            pos       <= is_end ? '0 : pos + 1'b1;
            st        <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  datsm_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(NW)) u_node_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (node_wdata),
    .raddr (AW'(p)),
    .rdata (node_rdata)
  );

  datsm_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(BASE_W)) u_check_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (check_wdata),
    .raddr (check_raddr),
    .rdata (check_rdata)
  );

  datsm_out_stage #(.POSITION_BITS(PB)) u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_start (rep_start),
    .in_end   (rep_end),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/datsm_checker.sv
`include "double_array_trie_stream_matcher_top_macros.svh"

module datsm_checker #(
  parameter int POSITION_BITS = 20
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [((2*POSITION_BITS+8)/8)*8-1:0] m_tdata,
  input logic        m_tlast
);
  import datsm_pkg::*;

  `DATSM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result dropped or changed while stalled")
  `DATSM_ASSERT_RESET(a_rst_out, clk, rst, !m_tvalid, "result shown after reset")
  `DATSM_ASSERT_RESET(a_rst_clear, clk, rst, !s_tready, "request taken during table clear")
  `DATSM_ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready && (s_tuser == REQ_SYMBOL || s_tuser == REQ_END), !s_tready, "second request taken while busy")
  `DATSM_ASSERT_NEXT(a_write_quiet, clk, rst, s_tvalid && s_tready && s_tuser == REQ_WRITE && !m_tvalid, !m_tvalid, "table write produced a result")

endmodule

bind double_array_trie_stream_matcher_top datsm_checker #(
  .POSITION_BITS(POSITION_BITS)
) u_datsm_checker (.*);

>>> dv/double_array_trie_stream_matcher_top_test.sv
`timescale 1ns / 100ps

module double_array_trie_stream_matcher_top_test;
  import datsm_pkg::*;

  localparam int DEPTH     = 4096;
  localparam int MAX_LEN   = 63;
  localparam int POS_W     = 20;
  localparam int PASS_MAX  = 17;
  localparam int SETTLE    = 120;      // longest request runs 17 passes
  localparam int WATCHDOG  = 20000;    // covers the table clearing pass after reset
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;

  double_array_trie_stream_matcher_top uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // one reported match
  typedef struct packed {
    logic [POS_W:0]   start_pos;
    logic [POS_W-1:0] end_pos;
    logic             last;
  } match_t;

  // predictor copy of the trie tables and scan state
  int          trie_base [DEPTH];
  int          trie_check[DEPTH];
  int unsigned trie_fail [DEPTH];
  int unsigned trie_len  [DEPTH];
  int unsigned scan_state;
  logic [POS_W-1:0] scan_pos;
  logic        max_mode;

  match_t      pending_matches[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          sender_calm;
  bit          receiver_calm;
  bit          timed_out;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // out-of-range slots read as zero in every table
  function automatic int rd_base(int unsigned i);
    return i < DEPTH ? trie_base[i] : 0;
  endfunction

  function automatic int rd_check(int unsigned i);
    return i < DEPTH ? trie_check[i] : 0;
  endfunction

  // queue a match for a terminal state, capped per request
  function automatic void report_match(ref match_t found[$], input int unsigned st,
                                       input logic [POS_W-1:0] endp);
    match_t m;
    if (found.size() >= PASS_MAX || rd_base(st) >= 0) return;
    m.end_pos   = endp;
    m.start_pos = {1'b0, endp} - (POS_W+1)'((st < DEPTH) ? trie_len[st] : 0);
    m.last      = 1'b0;
    found.insert(found.size(), m);
  endfunction

  // advances the matcher state for one request and queues its matches
  function automatic void predict_matches(logic [1:0] req, logic [11:0] code,
                                          logic [11:0] idx, logic [12:0] base_v,
                                          logic [12:0] check_v, logic [11:0] fail_v,
                                          logic [5:0] len_v);
    match_t found[$];
    int unsigned p, b, fl;
    int bp, chk;
    bit again;
    if (req == REQ_WRITE) begin
      trie_base[idx]  = int'(signed'(base_v));
      trie_check[idx] = int'(signed'(check_v));
      trie_fail[idx]  = 32'(fail_v);
      trie_len[idx]   = (len_v > MAX_LEN) ? 32'(MAX_LEN) : 32'(len_v);
      return;
    end
    if (req == REQ_END) begin
      if (!max_mode) report_match(found, scan_state, scan_pos);
      scan_state = 0;
      scan_pos   = '0;
    end else if (req == REQ_SYMBOL) begin
      p = scan_state;
      for (int pass = 0; pass < PASS_MAX; pass++) begin
        bp    = rd_base(p);
        b     = ((bp < 0) ? -bp : bp) + code;
        chk   = rd_check(b);
        fl    = (p < DEPTH) ? trie_fail[p] : 0;
        again = 1'b0;
        if (code == 0) begin
          if (!max_mode) report_match(found, p, scan_pos);
          p = 0;
        end else if (chk == int'(p) || (chk == -1 && p == 0)) begin
          p = b;
        end else if (fl != 0) begin
          if (!max_mode) report_match(found, p, scan_pos);
          p = fl;
          again = 1'b1;
        end else if (p == 0) begin
          if (!max_mode) report_match(found, p, scan_pos);
        end else begin
          if (!max_mode) report_match(found, p, scan_pos);
          p = 0;
          again = 1'b1;
        end
        if (max_mode) report_match(found, p, again ? scan_pos : scan_pos + POS_W'(1));
        if (!again) break;
      end
      scan_state = p;
      scan_pos   = scan_pos + POS_W'(1);
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_matches.insert(pending_matches.size(), found[i]);
  endfunction

  // sends one request and runs the predictor on acceptance
  task automatic send_request(logic [1:0] req, logic [11:0] code = '0,
                              logic [11:0] idx = '0, logic [12:0] base_v = '0,
                              logic [12:0] check_v = '0, logic [11:0] fail_v = '0,
                              logic [5:0] len_v = '0);
    int gap;
    if (!sender_calm && $urandom_range(99) < 13) begin
      gap = $urandom_range(4, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    // symbol_code, entry_index, entry_base, entry_check, entry_failure, entry_word_length
    s_tdata  <= {4'b0, len_v, fail_v, check_v, base_v, idx, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_matches(req, code, idx, base_v, check_v, fail_v, len_v);
  endtask

  task automatic write_slot(int idx, int base_v, int check_v, int fail_v, int len_v);
    send_request(REQ_WRITE, 12'($urandom), 12'(idx), 13'(base_v), 13'(check_v),
                 12'(fail_v), 6'(len_v));
  endtask

  // sender holds off until every match has arrived and the block has settled
  task automatic drain_matches();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_match_mode(logic mode);
    drain_matches();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    max_mode     = mode;
  endtask

  // three-level dictionary over codes 1..4 with random word ends and failure links
  task automatic load_dictionary();
    int g, leaf;
    write_slot(0, 0, 0, 0, 0);
    for (int s = 1; s <= 4; s++)
      write_slot(s, ($urandom_range(1) ? -1 : 1) * 8 * s, -1, 0, 1);
    for (int s = 1; s <= 4; s++)
      for (int c = 1; c <= 4; c++) begin
        g = 8 * s + c;
        write_slot(g, ($urandom_range(1) ? -1 : 1) * (64 + 5 * g), s,
                   $urandom_range(4), 2);
      end
    for (int s = 1; s <= 4; s++)
      for (int c = 1; c <= 4; c++)
        for (int d = 1; d <= 4; d++) begin
          g    = 8 * s + c;
          leaf = 64 + 5 * g + d;
          write_slot(leaf, $urandom_range(2) != 0 ? -1000 : 1000, g,
                     $urandom_range(1) ? 8 * $urandom_range(4, 1) + $urandom_range(4, 1)
                                       : $urandom_range(4),
                     $urandom_range(1) ? 3 : $urandom_range(63));
        end
  endtask

  task automatic send_text(int count);
    int dice;
    for (int i = 0; i < count; i++) begin
      dice = $urandom_range(99);
      if (dice < 5)       send_request(REQ_END, 12'($urandom));
      else if (dice < 10) send_request(REQ_SYMBOL, 12'd0);
      else if (dice < 15) send_request(REQ_SYMBOL, 12'($urandom));
      else                send_request(REQ_SYMBOL, 12'($urandom_range(4, 1)));
    end
  endtask

  // field extremes, root-only text, code zero, unused request type, then dictionary text
  task automatic test_directed_extremes();
    write_slot(0, 4095, 0, 0, 0);
    write_slot(4095, -4096, 4095, 4095, 63);
    write_slot(4094, 4095, -1, 0, 0);
    send_request(REQ_SYMBOL, 12'd4095);   // lands past the table end
    send_request(REQ_SYMBOL, 12'd4095);
    send_request(REQ_SYMBOL, 12'd0);
    send_request(REQ_END);
    send_request(REQ_SPARE, 12'hfff, 12'hfff, 13'h1fff, 13'h1fff, 12'hfff, 6'h3f);
    load_dictionary();
    send_request(REQ_SYMBOL, 12'd1);
    send_request(REQ_SYMBOL, 12'd2);
    send_request(REQ_SYMBOL, 12'd3);
    send_request(REQ_SYMBOL, 12'd0);
    send_request(REQ_SYMBOL, 12'd4);
    send_request(REQ_END);
  endtask

  // a failure link to itself loops until the pass limit
  task automatic test_failure_loop();
    write_slot(5, -40, 0, 5, 7);
    write_slot(1, -8, -1, 5, 1);
    send_request(REQ_SYMBOL, 12'd1);
    send_request(REQ_SYMBOL, 12'd7);
    send_request(REQ_END);
    // put both slots back as the dictionary has them
    write_slot(1, ($urandom_range(1) ? -1 : 1) * 8, -1, 0, 1);
    write_slot(5, 0, 0, 0, 0);
  endtask

  task automatic test_text_all_match();
    send_text(60);
    send_request(REQ_END);
  endtask

  task automatic test_text_maximum();
    receiver_calm = 1'b1;
    sender_calm   = 1'b1;
    send_text(30);
    receiver_calm = 1'b0;
    sender_calm   = 1'b0;
    send_text(40);
    send_request(REQ_END);
  endtask

  // raw random table writes and requests, then a fresh dictionary and text
  task automatic test_table_noise();
    for (int i = 0; i < 20; i++)
      send_request(2'($urandom), 12'($urandom), 12'($urandom), 13'($urandom),
                   13'($urandom), 12'($urandom), 6'($urandom));
    load_dictionary();
    send_text(20);
  endtask

  // compare each accepted match with the oldest prediction
  always @(posedge clk) begin
    match_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[POS_W:0], m_tdata[2*POS_W:POS_W+1], m_tlast};
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected match start %0d end %0d last %0b",
                   signed'(got.start_pos), got.end_pos, got.last);
      end else begin
        want = pending_matches[0];
        pending_matches.delete(0);
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("match mismatch: expected start %0d end %0d last %0b, got %0d %0d %0b",
                     signed'(want.start_pos), want.end_pos, want.last,
                     signed'(got.start_pos), got.end_pos, got.last);
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk)
    m_tready <= receiver_calm ? 1'b1 : ($urandom_range(99) >= 13);

  // cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) timed_out = 1'b1;
  end

  initial begin
    rst = 1'b1; cfg_wr_en = 1'b0; cfg_wr_data = 1'b0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = REQ_WRITE; m_tready = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      trie_base[i] = 0; trie_check[i] = 0; trie_fail[i] = 0; trie_len[i] = 0;
    end
    scan_state = 0; scan_pos = '0; max_mode = 1'b0;
    mismatch_count = 0; idle_cycles = 0; timed_out = 1'b0;
    sender_calm = 1'b0; receiver_calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        test_directed_extremes();
        set_match_mode(1'b0);
        test_failure_loop();
        test_text_all_match();
        set_match_mode(1'b1);
        test_failure_loop();
        test_text_maximum();
        set_match_mode(1'b0);
        test_table_noise();
        drain_matches();
      end
      begin
        wait (timed_out);
      end
    join_any
    disable fork;

    if (!timed_out && mismatch_count == 0 && pending_matches.size() == 0)
      $display("double_array_trie_stream_matcher_top test passed");
    else
      $display("double_array_trie_stream_matcher_top test failed");
    $finish;
  end

endmodule

>>> double_array_trie_stream_matcher_top.f
+incdir+sv
sv/datsm_pkg.sv
sv/datsm_ram.sv
sv/datsm_out_stage.sv
sv/double_array_trie_stream_matcher_top.sv
sv/datsm_checker.sv
dv/double_array_trie_stream_matcher_top_test.sv
